/* design/pss_pkg.sv */
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants for the plucked string voice
// Field widths, register indexes, reset values and noise generator constants.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int PERIOD_W    = 12;
  localparam int SEED_W      = 20;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 2;
  localparam int IN_TDATA_W  = 24;  // excite_sample, note_start, zero pad
  localparam int OUT_TDATA_W = 16;  // voice_sample

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SEED_W-1:0]          seed_t;
  typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;

  // register indexes
  localparam cfg_index_t CFG_PERIOD_LENGTH   = 2'd0;
  localparam cfg_index_t CFG_EXTERNAL_EXCITE = 2'd1;
  localparam cfg_index_t CFG_RANDOM_DECAY    = 2'd2;
  localparam cfg_index_t CFG_DECAY_LIMIT     = 2'd3;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd100;
  localparam seed_t               LIMIT_RESET  = 20'd981287;

  // LCG: seed = seed * 853 mod 981287
  localparam logic [9:0] NOISE_MUL   = 10'd853;
  localparam seed_t      NOISE_MOD   = 20'd981287;
  localparam seed_t      NOISE_SEED0 = 20'd1996;
  // excitation scale divisor (modulus minus one)
  localparam seed_t      NOISE_DIV   = 20'd981286;

  // quotient estimates, low by at most one
  localparam logic [29:0] LCG_RECIP = 30'((64'd853 << 40) / 64'd981287);
  localparam logic [20:0] EXC_RECIP = 21'((64'd1 << 40) / 64'd981286);

endpackage

/* design/plucked_string_synth_core.sv */
// ----------------------------------------------------------------------------
// plucked_string_synth_core: Karplus-Strong plucked string voice
// Circular sample buffer in one synchronous RAM, LCG noise excitation and
// optional random decay; one output word per input word.
// ----------------------------------------------------------------------------
//
// channel   | dir | handshake              | payload (lowest bit first)
// ----------+-----+------------------------+-----------------------------------
// s_axis    | in  | s_axis_tvalid/tready   | excite_sample[15:0], note_start[16]
// m_axis    | out | m_axis_tvalid/tready   | voice_sample[15:0]
// cfg       | in  | cfg_we (no wait)       | cfg_index, cfg_data
//
// Sequence: idle, read current slot, read previous slot, output, write-back
//   with external excitation and plain decay; noise excitation adds an LCG
//   step, then scaling to Q1.15, and random decay adds one LCG step. The shared
//   reciprocal-multiply LCG unit and the two RAM reads (current and previous
//   slot) shape this sequence. Reset: synchronous; afterwards a clearing pass
//   writes zeros to all MAX_PERIOD buffer entries, one per cycle, with s_axis_tready low.
// Stalls: a result waits in the output register; the sequencer only holds
//   when it has a new result and the register is still full.
//
module plucked_string_synth_core
  import pss_pkg::*;
#(
  parameter int MAX_PERIOD = 2048
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] excite_sample, [16] note_start
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] voice_sample
  input  logic                   cfg_we,
  input  cfg_index_t             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;  // buffer address
  localparam int SW = $clog2(MAX_PERIOD + 1);                     // holds MAX_PERIOD
  localparam int CW = (SW > PERIOD_W) ? SW : PERIOD_W;            // period compare
  localparam logic [SW-1:0] SIZE_MAX  = SW'(MAX_PERIOD);
  localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_PERIOD - 1);

  // sequencer states
  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_RD_CUR  = 4'd2;
  localparam logic [3:0] ST_RD_PREV = 4'd3;
  localparam logic [3:0] ST_DRAW_A  = 4'd4;
  localparam logic [3:0] ST_DRAW_B  = 4'd5;
  localparam logic [3:0] ST_DRAW_C  = 4'd6;
  localparam logic [3:0] ST_EXC_A   = 4'd7;
  localparam logic [3:0] ST_EXC_B   = 4'd8;
  localparam logic [3:0] ST_EXC_C   = 4'd9;
  localparam logic [3:0] ST_OUT     = 4'd10;
  localparam logic [3:0] ST_WB      = 4'd11;

  // configuration
  logic [PERIOD_W-1:0] period_length;
  logic                external_excite;
  logic                random_decay;
  seed_t               decay_limit;

  // control state
  logic [3:0]    state;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wp;
  logic [SW-1:0] note_age;
  seed_t         seed;
  logic          out_valid;

  // per-word working registers
  logic [SW-1:0] size;
  logic [AW-1:0] pos;
  logic [AW-1:0] prev_pos;
  logic          do_excite;
  logic          do_avg;
  logic          draw_decay;   // LCG step feeds the decay test, not excitation
  sample_t       excite_in;
  sample_t       cur;
  sample_t       out_data;
  logic [9:0]    q_lcg;
  logic [20:0]   r_lcg;
  logic [16:0]   q_exc;
  logic [20:0]   r_exc;

  // buffer RAM
  sample_t       mem [MAX_PERIOD];
  sample_t       rdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  sample_t       wr_data;

  // word setup
  logic [CW-1:0] period_ext;
  logic [SW-1:0] size_c;
  logic [AW-1:0] pos_c;
  logic [AW-1:0] prev_c;
  logic [SW-1:0] age_c;
  logic          note_start_in;

  // arithmetic
  logic [49:0] lcg_prod;
  logic [29:0] lcg_rem;
  seed_t       seed_new;
  logic [40:0] exc_prod;
  logic [36:0] exc_rem;
  logic [16:0] q_fin;
  sample_t     exc_val;
  sample_t     prev_val;
  logic [16:0] avg_sum;
  sample_t     avg;
  logic [SW-1:0] pos_inc;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign note_start_in = s_axis_tdata[16];

  // period clamp to 1..MAX_PERIOD, stale position restart, note age restart
  always_comb begin
    period_ext = CW'(period_length);
    if (period_length == '0) begin
      size_c = SW'(1);
    end else if (period_ext > CW'(MAX_PERIOD)) begin
      size_c = SIZE_MAX;
    end else begin
      size_c = SW'(period_ext);
    end
    pos_c  = (SW'(wp) >= size_c) ? '0 : wp;
    prev_c = (pos_c == '0) ? AW'(size_c - SW'(1)) : pos_c - AW'(1);
    age_c  = note_start_in ? '0 : note_age;
  end

  // LCG step: quotient estimate, remainder, one correction
  always_comb begin
    lcg_prod = 50'(seed) * 50'(LCG_RECIP);
    lcg_rem  = 30'(seed) * 30'(NOISE_MUL) - 30'(q_lcg) * 30'(NOISE_MOD);
    seed_new = (r_lcg >= 21'(NOISE_MOD)) ? 20'(r_lcg - 21'(NOISE_MOD)) : r_lcg[19:0];
  end

  // excitation: floor(65536 * seed / 981286) - 32768, saturated
  always_comb begin
    exc_prod = 41'(seed) * 41'(EXC_RECIP);
    exc_rem  = 37'({seed, 16'b0}) - 37'(q_exc) * 37'(NOISE_DIV);
    q_fin    = q_exc + 17'(r_exc >= 21'(NOISE_DIV));
    exc_val  = q_fin[16] ? sample_t'(16'h7FFF) : sample_t'({~q_fin[15], q_fin[14:0]});
  end

  // floor average with the previous slot; a one-slot string sees itself
  always_comb begin
    prev_val = (prev_pos == pos) ? cur : rdata;
    avg_sum  = {cur[15], cur} + {prev_val[15], prev_val};
    avg      = avg_sum[16:1];
    pos_inc  = SW'(pos) + SW'(1);
  end

  // RAM port control
  always_comb begin
    rd_en   = (state == ST_RD_CUR) || (state == ST_RD_PREV);
    rd_addr = (state == ST_RD_CUR) ? pos : prev_pos;
    wr_en   = (state == ST_CLEAR) || (state == ST_WB);
    wr_addr = (state == ST_CLEAR) ? clr_addr : pos;
    if (state == ST_CLEAR) begin
      wr_data = '0;
    end else begin
      wr_data = do_avg ? avg : cur;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_addr        <= '0;
      wp              <= '0;
      note_age        <= '0;
      seed            <= NOISE_SEED0;
      out_valid       <= 1'b0;
      period_length   <= PERIOD_RESET;
      external_excite <= 1'b0;
      random_decay    <= 1'b0;
      decay_limit     <= LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PERIOD_LENGTH:   period_length   <= cfg_data[PERIOD_W-1:0];
          CFG_EXTERNAL_EXCITE: external_excite <= cfg_data[0];
          CFG_RANDOM_DECAY:    random_decay    <= cfg_data[0];
          CFG_DECAY_LIMIT:     decay_limit     <= cfg_data;
          default: ;
        endcase
      end

      // ST_OUT reloads the register itself when the word drains
      if (out_valid && m_axis_tready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == ADDR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            size      <= size_c;
            pos       <= pos_c;
            prev_pos  <= prev_c;
            note_age  <= age_c;
            do_excite <= (age_c < size_c);
            excite_in <= s_axis_tdata[SAMPLE_W-1:0];
            state     <= ST_RD_CUR;
          end
        end
        ST_RD_CUR: begin
          state <= ST_RD_PREV;
        end
        ST_RD_PREV: begin
          // rdata holds the current slot here
          if (!do_excite) begin
            cur   <= rdata;
            state <= ST_OUT;
          end else if (external_excite) begin
            cur   <= excite_in;
            state <= ST_OUT;
          end else begin
            draw_decay <= 1'b0;
            state      <= ST_DRAW_A;
          end
        end
        ST_DRAW_A: begin
          q_lcg <= lcg_prod[49:40];
          state <= ST_DRAW_B;
        end
        ST_DRAW_B: begin
          r_lcg <= lcg_rem[20:0];
          state <= ST_DRAW_C;
        end
        ST_DRAW_C: begin
          seed <= seed_new;
          if (draw_decay) begin
            do_avg <= (seed_new < decay_limit);
            state  <= ST_WB;
          end else begin
            state <= ST_EXC_A;
          end
        end
        ST_EXC_A: begin
          q_exc <= exc_prod[40:24];
          state <= ST_EXC_B;
        end
        ST_EXC_B: begin
          r_exc <= exc_rem[20:0];
          state <= ST_EXC_C;
        end
        ST_EXC_C: begin
          cur   <= exc_val;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_data  <= cur;
            if (random_decay) begin
              draw_decay <= 1'b1;
              state      <= ST_DRAW_A;
            end else begin
              do_avg <= 1'b1;
              state  <= ST_WB;
            end
          end
        end
        ST_WB: begin
          // RAM write of the averaged (or kept) slot happens this cycle
          wp <= (pos_inc == size) ? '0 : pos_inc[AW-1:0];
          if (note_age < SIZE_MAX) begin
            note_age <= note_age + SW'(1);
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/pss_checker.sv */
// ----------------------------------------------------------------------------
// pss_checker: port-level checks for the plucked string voice
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module pss_checker
  import pss_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;   // words taken in, results not yet delivered

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
    end
  end

  // clearing pass follows reset
  a_clear_after_rst: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input ready right after reset");

  // one word at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("input ready in the cycle after an accept");

  // no result without a word behind it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 2'd0)
    else $error("output word with no pending input");

  // at most one result waiting plus one word at work
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many words in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

endmodule

bind plucked_string_synth_core pss_checker u_pss_checker (.*);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: plucked string voice core
// Drives excitation words and note starts through the input stream and
// checks each output word against an in-bench model of the string buffer,
// note age and noise generator. Covers directed corners, then random phases
// with random register settings and random sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench
  import pss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN       = 2048;
  localparam int SETTLE_CYCLES = 32;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_WORDS   = 50;
  localparam int SHOW_LIMIT    = 10;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] excite_sample, [16] note_start
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [15:0] voice_sample
  logic                   cfg_we;
  cfg_index_t             cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  plucked_string_synth_core #(
    .MAX_PERIOD(MAX_LEN)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous hard stop; a correct run needs well under a tenth of this
  initial begin
    #5ms;
    $display("Timeout: output words stopped arriving");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // String model: buffer, position, note age, LCG seed and register mirror
  // --------------------------------------------------------------------------
  sample_t             string_mem [0:MAX_LEN-1];
  int unsigned         slot_pos;
  int unsigned         note_age;
  seed_t               lcg_seed;
  logic [PERIOD_W-1:0] cfg_period;
  logic                cfg_ext;
  logic                cfg_rand;
  seed_t               cfg_limit;

  sample_t voice_expect_q [$];   // expected voice_sample, oldest first

  int error_count;
  int words_sent;
  int words_checked;
  int phases_run;

  int send_idle_pct;
  int stall_pct;

  function automatic void string_model_reset();
    foreach (string_mem[i]) string_mem[i] = '0;
    slot_pos   = 0;
    note_age   = 0;
    lcg_seed   = NOISE_SEED0;
    cfg_period = PERIOD_RESET;
    cfg_ext    = 1'b0;
    cfg_rand   = 1'b0;
    cfg_limit  = LIMIT_RESET;
  endfunction

  function automatic seed_t lcg_next();
    lcg_seed = seed_t'((64'(lcg_seed) * 64'(NOISE_MUL)) % 64'(NOISE_MOD));
    return lcg_seed;
  endfunction

  // scale seed to Q1.15: floor(65536*seed/981286) - 32768, top end saturates
  function automatic sample_t noise_to_sample(seed_t s);
    longint scaled;
    scaled = longint'((64'(s) * 64'd65536) / 64'(NOISE_DIV)) - 32768;
    if (scaled > 32767) scaled = 32767;
    return sample_t'(scaled);
  endfunction

  // one tick of the string: returns the voice word and updates the model
  function automatic sample_t string_tick(sample_t excite, logic note_start);
    int unsigned      span;
    int unsigned      prev_pos;
    sample_t          cur;
    logic signed [16:0] pair_sum;
    logic             do_avg;
    span = cfg_period;
    if (span == 0) span = 1;
    if (span > MAX_LEN) span = MAX_LEN;
    // position left over from a longer period restarts at zero
    if (slot_pos >= span) slot_pos = 0;
    if (note_start) note_age = 0;
    if (note_age < span)
      string_mem[slot_pos] = cfg_ext ? excite : noise_to_sample(lcg_next());
    cur = string_mem[slot_pos];
    prev_pos = (slot_pos == 0) ? span - 1 : slot_pos - 1;
    // decay draw follows any excitation draw
    do_avg = 1'b1;
    if (cfg_rand) do_avg = (lcg_next() < cfg_limit);
    if (do_avg) begin
      pair_sum = cur + string_mem[prev_pos];
      string_mem[slot_pos] = sample_t'(pair_sum >>> 1);
    end
    slot_pos++;
    if (slot_pos >= span) slot_pos = 0;
    if (note_age < MAX_LEN) note_age++;
    return cur;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stall, compare at the rising edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= stall_pct);
  end

  task automatic flag_error(string what, sample_t want, sample_t got);
    error_count++;
    if (error_count <= SHOW_LIMIT)
      $display("%0t: %s: expected voice_sample %0d (0x%04h), got %0d (0x%04h)",
               $realtime, what, want, want, got, got);
  endtask

  always @(posedge clk) begin
    sample_t want;
    sample_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = sample_t'(m_axis_tdata[SAMPLE_W-1:0]);
      if (voice_expect_q.size() == 0) begin
        flag_error("unexpected word", '0, got);
      end else begin
        want = voice_expect_q.pop_front();
        if (got !== want) flag_error("voice mismatch", want, got);
      end
      words_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers; all start and end at a falling edge
  // --------------------------------------------------------------------------
  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 66; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 66; end
      default: begin send_idle_pct = 29; stall_pct = 29; end
    endcase
  endtask

  // sends one word; tvalid stays high afterwards so back-to-back words flow
  task automatic send_word(sample_t excite, logic note_start);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_TDATA_W'({note_start, excite});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    voice_expect_q.push_back(string_tick(excite, note_start));
    words_sent++;
    @(negedge clk);
  endtask

  // stop sending, let every expected word arrive, then let the last
  // buffer write-back finish before any register changes
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (voice_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      CFG_PERIOD_LENGTH:   cfg_period = value[PERIOD_W-1:0];
      CFG_EXTERNAL_EXCITE: cfg_ext    = value[0];
      CFG_RANDOM_DECAY:    cfg_rand   = value[0];
      CFG_DECAY_LIMIT:     cfg_limit  = value[SEED_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset settings: period 100, noise excitation, plain decay; input
  // excitation is ignored, so feed it extremes
  task automatic test_noise_defaults();
    set_idling(0);
    send_word(16'sh7FFF, 1'b1);
    send_word(16'sh8000, 1'b0);
    send_word(16'shFFFF, 1'b0);
    wait_drained();
  endtask

  // external excitation at the sample extremes; after the first period the
  // stored values are averaged, negative sums included (floor rounding)
  task automatic test_external_extremes();
    set_idling(0);
    write_reg(CFG_PERIOD_LENGTH, 20'd4);
    write_reg(CFG_EXTERNAL_EXCITE, 20'd1);
    send_word(16'sh7FFF, 1'b1);
    send_word(16'sh8000, 1'b0);
    send_word(16'shFFFF, 1'b0);
    send_word(16'sh0001, 1'b0);
    send_word(16'sh0000, 1'b0);
    send_word(16'sh0000, 1'b0);
    wait_drained();
  endtask

  // zero period acts as one, oversize period clamps to the buffer size,
  // shortening past the position wraps it, growing mid-note excites again
  task automatic test_period_edges();
    set_idling(0);
    write_reg(CFG_PERIOD_LENGTH, 20'd0);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh7FFF, 1'b0);
    wait_drained();
    write_reg(CFG_PERIOD_LENGTH, 20'hFFFFF);
    send_word(16'sh5A5A, 1'b1);
    wait_drained();
    write_reg(CFG_PERIOD_LENGTH, 20'd8);
    send_word(16'sh1234, 1'b1);
    send_word(16'shEDCB, 1'b0);
    send_word(16'sh4000, 1'b0);
    wait_drained();
    write_reg(CFG_PERIOD_LENGTH, 20'd2);
    send_word(16'shC000, 1'b0);
    wait_drained();
    write_reg(CFG_PERIOD_LENGTH, 20'd3);
    send_word(16'sh0100, 1'b1);
    send_word(16'shFF00, 1'b0);
    send_word(16'sh7F00, 1'b0);
    wait_drained();
    write_reg(CFG_PERIOD_LENGTH, 20'd10);
    send_word(16'sh8001, 1'b0);
    send_word(16'sh2222, 1'b0);
    wait_drained();
  endtask

  // random decay with noise excitation: two draws per word; limit zero
  // never averages, limit above the modulus always does
  task automatic test_random_decay();
    set_idling(0);
    write_reg(CFG_PERIOD_LENGTH, 20'd5);
    write_reg(CFG_EXTERNAL_EXCITE, 20'd0);
    write_reg(CFG_RANDOM_DECAY, 20'd1);
    write_reg(CFG_DECAY_LIMIT, 20'd0);
    send_word(16'sh0000, 1'b1);
    send_word(16'sh0000, 1'b0);
    wait_drained();
    write_reg(CFG_DECAY_LIMIT, 20'hFFFFF);
    send_word(16'sh0000, 1'b0);
    send_word(16'sh0000, 1'b0);
    wait_drained();
    write_reg(CFG_DECAY_LIMIT, 20'd490643);
    send_word(16'sh0000, 1'b0);
    send_word(16'sh0000, 1'b0);
    wait_drained();
  endtask

  // random phases: fresh register settings, mostly short periods, idling
  // mode taken in turn by phase; upper data bits beyond each register may get random junk
  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] junk;
    logic [PERIOD_W-1:0]   period;
    seed_t                 limit;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(9))
        0:       period = '0;
        1:       period = PERIOD_W'(MAX_LEN);
        2:       period = PERIOD_W'($urandom_range(MAX_LEN + 1, 4095));
        default: period = PERIOD_W'($urandom_range(1, 24));
      endcase
      case ($urandom_range(5))
        0:       limit = '0;
        1:       limit = '1;
        2:       limit = NOISE_DIV;
        3:       limit = NOISE_MOD;
        default: limit = seed_t'($urandom);
      endcase
      junk = $urandom_range(1) ? CFG_DATA_W'($urandom) : '0;
      write_reg(CFG_PERIOD_LENGTH, {junk[CFG_DATA_W-1:PERIOD_W], period});
      junk = $urandom_range(1) ? CFG_DATA_W'($urandom) : '0;
      write_reg(CFG_EXTERNAL_EXCITE, {junk[CFG_DATA_W-1:1], 1'($urandom)});
      junk = $urandom_range(1) ? CFG_DATA_W'($urandom) : '0;
      write_reg(CFG_RANDOM_DECAY, {junk[CFG_DATA_W-1:1], 1'($urandom)});
      write_reg(CFG_DECAY_LIMIT, limit);
      set_idling(ph % 4);
      // usually a new note per phase; otherwise the period changes mid-note
      send_word(sample_t'($urandom), $urandom_range(3) != 0);
      for (int n = 1; n < PHASE_WORDS; n++)
        send_word(sample_t'($urandom), $urandom_range(15) == 0);
      wait_drained();
      phases_run++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_PERIOD_LENGTH;
    cfg_data      = '0;
    error_count   = 0;
    words_sent    = 0;
    words_checked = 0;
    phases_run    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    string_model_reset();

    repeat (2) @(negedge clk);
    rst = 1'b0;
    // the core clears its buffer after reset with tready low
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);

    test_noise_defaults();
    test_external_extremes();
    test_period_edges();
    test_random_decay();
    test_random_phases();

    $display("Checked %0d of %0d voice words: directed corners plus %0d random phases",
             words_checked, words_sent, phases_run);
    $display("Periods zero through oversize, both excitation sources, plain and random decay");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
design/pss_pkg.sv
design/plucked_string_synth_core.sv
design/pss_checker.sv
tb/testbench.sv
